// ----- sv/rla_pkg.sv -----
// ----------------------------------------------------------------------------
// rla_pkg
// shared types and constants for the rgb lookup table block
// ----------------------------------------------------------------------------
package rla_pkg;

    // default table depth
    localparam int TABLE_ENTRIES_DEF = 256;

    // luminance weights, q0.16, they sum to 65536
    localparam logic [15:0] LUM_COEF_R = 16'd13933;
    localparam logic [15:0] LUM_COEF_G = 16'd46871;
    localparam logic [15:0] LUM_COEF_B = 16'd4732;

    // width of one weighted product and of their sum
    localparam int PROD_W = 24;

    // item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // table selects
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [1:0] table_select;
        logic [7:0] entry_index;
        logic [7:0] entry_value;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pixel_out_t;

    // item held in the product stage, with its lookup indexes resolved
    typedef struct packed {
        logic       kind;
        logic [1:0] table_select;
        logic [7:0] entry_index;
        logic [7:0] entry_value;
        logic [7:0] red_idx;
        logic [7:0] green_idx;
        logic [7:0] blue_idx;
    } lookup_t;

    // write and read access to one table
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_idx;
        logic [7:0] wr_data;
        logic       rd_en;
        logic [7:0] rd_idx;
    } tbl_req_t;

endpackage

// ----- sv/rla_index.sv -----
// ----------------------------------------------------------------------------
// rla_index
// product stage: registers the word and its weighted channels, forms the
// lookup indexes for the tables
// ----------------------------------------------------------------------------
module rla_index (
    input  logic                aclk,
    input  logic                load,
    input  logic                mode,
    input  rla_pkg::pixel_in_t  s_data,
    output rla_pkg::lookup_t    look
);

    logic                        kind_reg;
    logic [1:0]                  sel_reg;
    logic [7:0]                  idx_reg;
    logic [7:0]                  val_reg;
    logic [7:0]                  red_reg;
    logic [7:0]                  green_reg;
    logic [7:0]                  blue_reg;
    logic                        mode_reg;
    logic [rla_pkg::PROD_W-1:0]  prod_r_reg;
    logic [rla_pkg::PROD_W-1:0]  prod_g_reg;
    logic [rla_pkg::PROD_W-1:0]  prod_b_reg;
    logic [rla_pkg::PROD_W-1:0]  lum_sum;
    logic [7:0]                  lum;

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg   <= s_data.kind;
            sel_reg    <= s_data.table_select;
            idx_reg    <= s_data.entry_index;
            val_reg    <= s_data.entry_value;
            red_reg    <= s_data.red_in;
            green_reg  <= s_data.green_in;
            blue_reg   <= s_data.blue_in;
            mode_reg   <= mode;
            prod_r_reg <= rla_pkg::PROD_W'(s_data.red_in)
                          * rla_pkg::PROD_W'(rla_pkg::LUM_COEF_R);
            prod_g_reg <= rla_pkg::PROD_W'(s_data.green_in)
                          * rla_pkg::PROD_W'(rla_pkg::LUM_COEF_G);
            prod_b_reg <= rla_pkg::PROD_W'(s_data.blue_in)
                          * rla_pkg::PROD_W'(rla_pkg::LUM_COEF_B);
        end
    end

    // weights sum to one, so the sum never overflows and y fits a byte
    assign lum_sum = prod_r_reg + prod_g_reg + prod_b_reg;
    assign lum     = lum_sum[rla_pkg::PROD_W-1 -: 8];

    always_comb begin
        look.kind         = kind_reg;
        look.table_select = sel_reg;
        look.entry_index  = idx_reg;
        look.entry_value  = val_reg;
        look.red_idx      = mode_reg ? lum : red_reg;
        look.green_idx    = mode_reg ? lum : green_reg;
        look.blue_idx     = mode_reg ? lum : blue_reg;
    end

endmodule

// ----- sv/rla_table.sv -----
// ----------------------------------------------------------------------------
// rla_table
// one byte table: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module rla_table #(
    parameter int TABLE_ENTRIES = rla_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              aclk,
    input  rla_pkg::tbl_req_t req,
    output logic [7:0]        rd_data
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int EXT_W  = (ADDR_W > 8) ? ADDR_W : 8;

    logic [7:0]       lut_mem [TABLE_ENTRIES];
    logic [EXT_W-1:0] wr_ext;
    logic [EXT_W-1:0] rd_ext;
    logic             wr_ok;
    logic             rd_ok;
    logic             rd_ok_reg;
    logic [7:0]       rd_data_reg;

    assign wr_ext = EXT_W'(req.wr_idx);
    assign rd_ext = EXT_W'(req.rd_idx);
    // indexes past the end: writes dropped, reads give zero
    assign wr_ok  = 32'(req.wr_idx) < 32'(TABLE_ENTRIES);
    assign rd_ok  = 32'(req.rd_idx) < 32'(TABLE_ENTRIES);

    always_ff @(posedge aclk) begin
        if (req.wr_en && wr_ok) begin
            lut_mem[wr_ext[ADDR_W-1:0]] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= lut_mem[rd_ext[ADDR_W-1:0]];
            rd_ok_reg   <= rd_ok;
        end
    end

    assign rd_data = rd_ok_reg ? rd_data_reg : 8'd0;

endmodule

// ----- sv/rgb_lut_apply.sv -----
// ----------------------------------------------------------------------------
// rgb_lut_apply
// remaps rgb pixels through three loadable byte tables, per channel or by
// luminance
// ----------------------------------------------------------------------------
// The block takes one word per clock on s_ and, for every pixel word, returns
// one remapped pixel on m_; table write words leave no result and reach their
// table in the cycle after acceptance. Throughput is one word per clock, set
// by the one read port and one write port of each table memory, and it holds
// as long as m_ready stays high. Words pass through two stages: a product
// stage that registers the three weighted channels (q0.16 luminance weights),
// then the table read, whose registered data is the output register. Writes
// and reads hit the tables in the same stage and in word order, so a pixel
// right behind a write to the same entry already sees the new byte. Table
// contents are undefined after reset; a pixel must only read entries written
// before. The user writes luminance_mode through cfg_ only while the block is
// idle; the block does not enforce it. It is sampled with each accepted word.
// ----------------------------------------------------------------------------
module rgb_lut_apply #(
    parameter int TABLE_ENTRIES = rla_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input words
    input  logic                s_valid,
    output logic                s_ready,
    input  rla_pkg::pixel_in_t  s_data,
    // result words
    output logic                m_valid,
    input  logic                m_ready,
    output rla_pkg::pixel_out_t m_data,
    // mode register
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_wdata
);

    logic              mode_reg, mode_next;
    logic              p_valid_reg, p_valid_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;
    logic              p_leave;
    logic              load;
    logic              wr_fire;
    logic              rd_fire;
    rla_pkg::lookup_t  look;
    rla_pkg::tbl_req_t red_req;
    rla_pkg::tbl_req_t green_req;
    rla_pkg::tbl_req_t blue_req;

    // mode register, always writable
    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? cfg_wdata : mode_reg;

    // output stage frees when empty or taken
    assign out_free = !m_valid_reg || m_ready;
    // write words retire from the product stage without the output stage
    assign wr_fire  = p_valid_reg && (look.kind == rla_pkg::KIND_WRITE);
    assign rd_fire  = p_valid_reg && (look.kind == rla_pkg::KIND_PIXEL) && out_free;
    assign p_leave  = wr_fire || rd_fire;
    assign load     = !p_valid_reg || p_leave;
    assign s_ready  = load;

    assign p_valid_next = load ? s_valid : p_valid_reg;
    assign m_valid_next = out_free ? rd_fire : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= 1'b0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    rla_index u_index (
        .aclk   (aclk),
        .load   (load),
        .mode   (mode_reg),
        .s_data (s_data),
        .look   (look)
    );

    // table accesses for the word in the product stage
    always_comb begin
        red_req.wr_en    = wr_fire && (look.table_select == rla_pkg::SEL_RED);
        red_req.wr_idx   = look.entry_index;
        red_req.wr_data  = look.entry_value;
        red_req.rd_en    = rd_fire;
        red_req.rd_idx   = look.red_idx;

        green_req.wr_en   = wr_fire && (look.table_select == rla_pkg::SEL_GREEN);
        green_req.wr_idx  = look.entry_index;
        green_req.wr_data = look.entry_value;
        green_req.rd_en   = rd_fire;
        green_req.rd_idx  = look.green_idx;

        blue_req.wr_en   = wr_fire && (look.table_select == rla_pkg::SEL_BLUE);
        blue_req.wr_idx  = look.entry_index;
        blue_req.wr_data = look.entry_value;
        blue_req.rd_en   = rd_fire;
        blue_req.rd_idx  = look.blue_idx;
    end

    rla_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_red_table (
        .aclk    (aclk),
        .req     (red_req),
        .rd_data (m_data.red_out)
    );

    rla_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_green_table (
        .aclk    (aclk),
        .req     (green_req),
        .rd_data (m_data.green_out)
    );

    rla_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_blue_table (
        .aclk    (aclk),
        .req     (blue_req),
        .rd_data (m_data.blue_out)
    );

    assign m_valid = m_valid_reg;

endmodule

// ----- dv/tb_rgb_lut_apply.sv -----
// ----------------------------------------------------------------------------
// tb_rgb_lut_apply
// self-checking bench for the rgb lookup table block
// ----------------------------------------------------------------------------
// Table writes and pixels go in on s_. Accepted writes to a used select update
// a bench-side copy of the three tables, and each pixel queues the pixel that
// should come back. Results on m_ are checked in order against that queue.
// Directed tests cover the channel extremes, the unused table select,
// read-after-write and the luminance extremes. Random traffic then runs in
// both modes. Before a pixel is sent, the stimulus loads every table entry
// that the pixel will read, so no never-written entry is read. The sender
// works in random bursts and the receiver stalls in its own styles.
// ----------------------------------------------------------------------------
module tb_rgb_lut_apply;
    timeunit 1ns;
    timeprecision 1ps;

    // write target that selects no table
    localparam logic [1:0] SEL_UNUSED = 2'd3;

    // receiver stall styles
    localparam int RX_FREE   = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_BURSTY = 3;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    rla_pkg::pixel_in_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    rla_pkg::pixel_out_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_wdata = 1'b0;

    // bench copy of the block state
    logic [7:0] lut_model [3][256];
    logic       lum_mode = 1'b0;
    // entries the stimulus has already loaded (never-written entries are off limits)
    bit         loaded [3][256];

    rla_pkg::pixel_out_t expected_pixels [$];
    rla_pkg::pixel_out_t want;

    // sender state: s_held mirrors an s_valid that is still meant to be high
    bit s_held      = 1'b0;
    int burst_left  = 1;

    // receiver pattern state
    int rx_style    = RX_FREE;
    int rx_left     = 0;

    int mismatch_count = 0;
    int pixels_sent    = 0;
    int writes_sent    = 0;
    int ignored_sent   = 0;
    int lum_pixels     = 0;
    int results_seen   = 0;
    int mode_changes   = 0;

    rgb_lut_apply dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // luminance and lookup index helpers
    // ------------------------------------------------------------------

    // q0.16 weighted sum, truncated; the weights sum to one, so it fits 8 bits
    function automatic logic [7:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [31:0] acc;
        acc = 32'(rla_pkg::LUM_COEF_R) * 32'(r)
            + 32'(rla_pkg::LUM_COEF_G) * 32'(g)
            + 32'(rla_pkg::LUM_COEF_B) * 32'(b);
        return acc[23:16];
    endfunction

    // table index per channel under the current mode
    function automatic logic [2:0][7:0] lookup_of(logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b);
        logic [2:0][7:0] ix;
        logic [7:0]      y;
        y = luma_of(r, g, b);
        ix[rla_pkg::SEL_RED]   = lum_mode ? y : r;
        ix[rla_pkg::SEL_GREEN] = lum_mode ? y : g;
        ix[rla_pkg::SEL_BLUE]  = lum_mode ? y : b;
        return ix;
    endfunction

    // channel value biased toward the extremes
    function automatic logic [7:0] pick_channel();
        int p;
        p = $urandom_range(0, 7);
        if (p == 0) return 8'h00;
        if (p == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // prediction: a table write to a used select accepted on s_ updates the
    // table copy, and a pixel queues its remapped result
    // ------------------------------------------------------------------
    task automatic remap_word(input rla_pkg::pixel_in_t w);
        logic [2:0][7:0] ix;
        if (w.kind == rla_pkg::KIND_WRITE) begin
            // select 3 touches no table
            if (w.table_select != SEL_UNUSED)
                lut_model[w.table_select][w.entry_index] = w.entry_value;
        end else begin
            ix = lookup_of(w.red_in, w.green_in, w.blue_in);
            expected_pixels.push_back('{
                red_out:   lut_model[rla_pkg::SEL_RED][ix[rla_pkg::SEL_RED]],
                green_out: lut_model[rla_pkg::SEL_GREEN][ix[rla_pkg::SEL_GREEN]],
                blue_out:  lut_model[rla_pkg::SEL_BLUE][ix[rla_pkg::SEL_BLUE]]});
            if (lum_mode)
                lum_pixels++;
        end
    endtask

    // signals are read at the edge before any update of this step lands
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            remap_word(s_data);
    end

    // ------------------------------------------------------------------
    // result checker: in order against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", m_data));
            end else begin
                want = expected_pixels.pop_front();
                if (m_data.red_out !== want.red_out)
                    report_mismatch($sformatf("red_out %h, expected %h",
                                              m_data.red_out, want.red_out));
                if (m_data.green_out !== want.green_out)
                    report_mismatch($sformatf("green_out %h, expected %h",
                                              m_data.green_out, want.green_out));
                if (m_data.blue_out !== want.blue_out)
                    report_mismatch($sformatf("blue_out %h, expected %h",
                                              m_data.blue_out, want.blue_out));
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: switches between free flow, coin-flip, sparse and bursty
    // stalls, each style held for a random stretch
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_style = $urandom_range(RX_FREE, RX_BURSTY);
            rx_left  = $urandom_range(16, 160);
        end else begin
            rx_left--;
        end
        case (rx_style)
            RX_FREE:   m_ready <= 1'b1;
            RX_HALF:   m_ready <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: m_ready <= ($urandom_range(0, 9) == 0);
            default:   m_ready <= ((rx_left % 32) >= 20);
        endcase
    end

    // ------------------------------------------------------------------
    // stimulus primitives
    // ------------------------------------------------------------------

    // one word on s_; valid stays up across a burst, then drops for a gap
    task automatic send_word(input rla_pkg::pixel_in_t w);
        s_data  <= w;
        s_valid <= 1'b1;
        s_held   = 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (w.kind == rla_pkg::KIND_PIXEL)
            pixels_sent++;
        else if (w.table_select == SEL_UNUSED)
            ignored_sent++;
        else
            writes_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            s_held   = 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
            // mostly short bursts, now and then a long run with no idling
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
    endtask

    task automatic send_entry(input logic [1:0] sel, input logic [7:0] idx,
                              input logic [7:0] val);
        rla_pkg::pixel_in_t w;
        w.kind         = rla_pkg::KIND_WRITE;
        w.red_in       = 8'($urandom_range(0, 255));
        w.green_in     = 8'($urandom_range(0, 255));
        w.blue_in      = 8'($urandom_range(0, 255));
        w.table_select = sel;
        w.entry_index  = idx;
        w.entry_value  = val;
        send_word(w);
        if (sel != SEL_UNUSED)
            loaded[sel][idx] = 1'b1;
    endtask

    // load any entry this pixel would read that has never been written
    task automatic preload_for(input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b);
        logic [2:0][7:0] ix;
        ix = lookup_of(r, g, b);
        for (int s = rla_pkg::SEL_RED; s <= rla_pkg::SEL_BLUE; s++) begin
            if (!loaded[s][ix[s]])
                send_entry(2'(s), ix[s], 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        rla_pkg::pixel_in_t w;
        preload_for(r, g, b);
        w.kind         = rla_pkg::KIND_PIXEL;
        w.red_in       = r;
        w.green_in     = g;
        w.blue_in      = b;
        // unused on a pixel, but kept toggling
        w.table_select = 2'($urandom_range(0, 3));
        w.entry_index  = 8'($urandom_range(0, 255));
        w.entry_value  = 8'($urandom_range(0, 255));
        send_word(w);
    endtask

    // drop valid, wait for every expected result, then let a write settle
    task automatic drain();
        if (s_held) begin
            s_valid <= 1'b0;
            s_held   = 1'b0;
        end
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // mode register write; only called with the block idle
    task automatic write_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_wdata <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        lum_mode = mode;
        mode_changes++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // per-channel lookups at index 0 and 255 with extreme table bytes
    task automatic test_channel_extremes();
        write_mode(1'b0);
        send_entry(rla_pkg::SEL_RED,   8'h00, 8'h00);
        send_entry(rla_pkg::SEL_GREEN, 8'h00, 8'hFF);
        send_entry(rla_pkg::SEL_BLUE,  8'h00, 8'hA5);
        send_entry(rla_pkg::SEL_RED,   8'hFF, 8'hFF);
        send_entry(rla_pkg::SEL_GREEN, 8'hFF, 8'h00);
        send_entry(rla_pkg::SEL_BLUE,  8'hFF, 8'h5A);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'hFF);
    endtask

    // a write to the unused select must leave all three tables alone
    task automatic test_unused_select();
        send_entry(SEL_UNUSED, 8'h00, 8'h77);
        send_entry(SEL_UNUSED, 8'hFF, 8'h88);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
    endtask

    // pixel right behind a write to the entry it reads sees the new byte
    task automatic test_read_after_write();
        send_entry(rla_pkg::SEL_GREEN, 8'hFF, 8'h3C);
        send_pixel(8'h00, 8'hFF, 8'h00);
    endtask

    // luminance of black, white and each pure primary
    task automatic test_luminance_extremes();
        drain();
        write_mode(1'b1);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
    endtask

    // random mix of writes, rewrites followed by a read of that entry, and pixels
    task automatic test_random_traffic(input logic mode, input int quota);
        int              start;
        int              p;
        logic [7:0]      r, g, b;
        logic [2:0][7:0] ix;
        logic [1:0]      sel;
        drain();
        write_mode(mode);
        start = pixels_sent + writes_sent;
        while (pixels_sent + writes_sent - start < quota) begin
            p = $urandom_range(0, 99);
            if (p < 25) begin
                sel = ($urandom_range(0, 9) == 0) ? SEL_UNUSED : 2'($urandom_range(0, 2));
                send_entry(sel, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else begin
                r = pick_channel();
                g = pick_channel();
                b = pick_channel();
                if (p < 40) begin
                    // overwrite one of the entries the pixel reads just ahead of it
                    preload_for(r, g, b);
                    ix  = lookup_of(r, g, b);
                    sel = 2'($urandom_range(0, 2));
                    send_entry(sel, ix[sel], 8'($urandom_range(0, 255)));
                end
                send_pixel(r, g, b);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_channel_extremes();
        test_unused_select();
        test_read_after_write();
        test_luminance_extremes();
        test_random_traffic(1'b1, 310);
        test_random_traffic(1'b0, 310);
        test_random_traffic(1'b1, 310);
        test_random_traffic(1'b0, 300);

        drain();
        repeat (10) @(posedge aclk);
        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));

        $display("covered %0d pixels (%0d by luminance), %0d table writes, %0d ignored",
                 pixels_sent, lum_pixels, writes_sent, ignored_sent);
        $display("checked %0d results over %0d mode writes, %0d errors",
                 results_seen, mode_changes, mismatch_count);
        if (mismatch_count == 0)
            $display("rgb_lut_apply: match");
        else
            $display("rgb_lut_apply: mismatch");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_pixels.size());
        $display("rgb_lut_apply: mismatch");
        $finish;
    end

endmodule
